// ===== hw/rtl/tpz_pkg.sv =====
// Shared types, constants and the sine table for the torus point plotter.
package tpz_pkg;

  localparam int WIDTH_DEF  = 80;
  localparam int HEIGHT_DEF = 24;
  localparam int QW         = 17;          // quotient bits of the divider
  localparam logic [3:0] BLANK = 4'd15;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PLOT  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic [15:0] depth;
    logic [3:0]  shade;
  } pix_t;

  typedef struct packed {
    logic signed [63:0] nx;     // WIDTH*den + 60*u
    logic signed [63:0] ny;     // HEIGHT*den + 30*v
    logic [47:0]        den;    // always positive
    logic [3:0]         shade;
  } proj_res_t;

  typedef logic [14:0] sin_tab_t [0:256];

  function automatic sin_tab_t build_sin();
    sin_tab_t tab;
    real ang;
    for (int k = 0; k <= 256; k++) begin
      ang = 3.14159265358979323846 * k / 512.0;
      tab[k] = 15'($rtoi($floor(16384.0 * $sin(ang) + 0.5)));
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin();

  // Q1.14 sine of a 10-bit angle code
  function automatic logic signed [15:0] sin_code(input logic [9:0] code);
    logic [8:0] r;
    logic [8:0] rr;
    logic signed [15:0] v;
    r  = {1'b0, code[7:0]};
    rr = 9'd256 - r;
    unique case (code[9:8])
      2'd0: v = signed'({1'b0, SIN_TAB[r]});
      2'd1: v = signed'({1'b0, SIN_TAB[rr]});
      2'd2: v = -signed'({1'b0, SIN_TAB[r]});
      default: v = -signed'({1'b0, SIN_TAB[rr]});
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] cos_code(input logic [9:0] code);
    return sin_code(code + 10'd256);
  endfunction

endpackage

// ===== hw/rtl/torus_point_zbuffer_plot_unit.sv =====
// Top level of the depth-buffered torus point plotter.
//
//  channel   handshake             fields
//  request   start / busy          req_type, theta, phi, pixel_addr
//  result    done (strobe)         kind, written, shade, depth
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Plot: the projection loads sine and cosine and steps the shared multiplier
// through the torus math; three divisions follow (x, y, inverse depth), then
// a read-modify-write of the pixel, which is skipped when the point is off screen.
// Read: done after the registered store read, or straight from idle for an
// address beyond the store and for the unused request type; clear sweeps the store,
// then gives done. After reset the same sweep runs with busy high.
// done carries each word for one cycle; there is no stall.
module torus_point_zbuffer_plot_unit #(
  parameter int WIDTH  = tpz_pkg::WIDTH_DEF,
  parameter int HEIGHT = tpz_pkg::HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [9:0]  theta,
  input  logic [9:0]  phi,
  input  logic [10:0] pixel_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        done,
  output logic [1:0]  kind,
  output logic        written,
  output logic [3:0]  shade,
  output logic [15:0] depth
);

  localparam int NPIX = WIDTH * HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int QW   = tpz_pkg::QW;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_PROJ, ST_DX, ST_DY, ST_DZ, ST_RMW, ST_RDW
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic                clr_reply;
  logic [9:0]          angle_a, angle_b;
  logic [9:0]          th_r, ph_r;
  logic                proj_start, proj_done;
  tpz_pkg::proj_res_t  proj_res, res;
  logic                div_start, div_done;
  logic [63:0]         div_num, div_dvs;
  logic [QW-1:0]       div_quo, qx, qy;
  logic                nx_neg, ny_neg;
  logic [15:0]         inv16;
  logic [AW-1:0]       o_addr, o_comb;
  logic                on_screen, keep;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  tpz_pkg::pix_t       mem_wdata, mem_rdata;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign on_screen = !nx_neg && !ny_neg && (qx != '0) && (qx < QW'(WIDTH)) &&
                     (qy != '0) && (qy < QW'(HEIGHT));
  assign o_comb    = AW'(qx) + AW'(AW'(qy) * AW'(WIDTH));
  assign keep      = inv16 > mem_rdata.depth;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '{depth: 16'd0, shade: tpz_pkg::BLANK};
    mem_raddr = AW'(pixel_addr);
    unique case (state)
      ST_CLR: mem_we = 1'b1;
      ST_DZ:  mem_raddr = o_comb;
      ST_RMW: begin
        mem_we    = keep;
        mem_waddr = o_addr;
        mem_wdata = '{depth: inv16, shade: res.shade};
      end
      default: mem_raddr = AW'(pixel_addr);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      if (cfg_index) begin
        angle_b <= cfg_data;
      end else begin
        angle_a <= cfg_data;
      end
    end
    if (rst) begin
      angle_a <= '0;
      angle_b <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      proj_start <= 1'b0;
      div_start  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      proj_start <= 1'b0;
      div_start  <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NPIX - 1)) begin
            state <= ST_IDLE;
            if (clr_reply) begin
              done    <= 1'b1;
              kind    <= tpz_pkg::REQ_CLEAR;
              written <= 1'b0;
              shade   <= 4'd0;
              depth   <= 16'd0;
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            kind    <= req_type;
            written <= 1'b0;
            shade   <= 4'd0;
            depth   <= 16'd0;
            unique case (tpz_pkg::req_t'(req_type))
              tpz_pkg::REQ_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= ST_CLR;
              end
              tpz_pkg::REQ_PLOT: begin
                th_r       <= theta;
                ph_r       <= phi;
                proj_start <= 1'b1;
                state      <= ST_PROJ;
              end
              tpz_pkg::REQ_READ: begin
                if (32'(pixel_addr) < NPIX) begin
                  state <= ST_RDW;
                end else begin
                  shade <= tpz_pkg::BLANK;
                  done  <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        ST_PROJ: begin
          if (proj_done) begin
            res       <= proj_res;
            nx_neg    <= proj_res.nx[63];
            ny_neg    <= proj_res.ny[63];
            div_num   <= proj_res.nx[63] ? 64'd0 : proj_res.nx;
            div_dvs   <= 64'({proj_res.den, 1'b0});
            div_start <= 1'b1;
            state     <= ST_DX;
          end
        end
        ST_DX: begin
          if (div_done) begin
            qx        <= div_quo;
            div_num   <= res.ny[63] ? 64'd0 : res.ny;
            div_dvs   <= 64'({res.den, 1'b0});
            div_start <= 1'b1;
            state     <= ST_DY;
          end
        end
        ST_DY: begin
          if (div_done) begin
            qy        <= div_quo;
            div_num   <= 64'd1 << 58;
            div_dvs   <= 64'(res.den);
            div_start <= 1'b1;
            state     <= ST_DZ;
          end
        end
        ST_DZ: begin
          if (div_done) begin
            inv16  <= div_quo[QW-1] ? 16'hffff : div_quo[15:0];
            o_addr <= o_comb;
            if (on_screen) begin
              state <= ST_RMW;
            end else begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_RMW: begin
          if (keep) begin
            written <= 1'b1;
            shade   <= res.shade;
            depth   <= inv16;
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_RDW: begin
          shade <= mem_rdata.shade;
          depth <= mem_rdata.depth;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  tpz_proj #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_proj (
    .clk     (clk),
    .rst     (rst),
    .start   (proj_start),
    .theta   (th_r),
    .phi     (ph_r),
    .angle_a (angle_a),
    .angle_b (angle_b),
    .done    (proj_done),
    .res     (proj_res)
  );

  tpz_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo)
  );

  tpz_mem #(
    .DEPTH  (NPIX),
    .ADDR_W (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== hw/rtl/tpz_mem.sv =====
// Pixel store: one write port, one read port, registered read data.
module tpz_mem #(
  parameter int DEPTH  = tpz_pkg::WIDTH_DEF * tpz_pkg::HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  tpz_pkg::pix_t      wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output tpz_pkg::pix_t      rdata
);

  tpz_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tpz_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tpz_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            num,
  input  logic [63:0]            dvs,
  output logic                   done,
  output logic [tpz_pkg::QW-1:0] quo
);

  localparam int CW = $clog2(tpz_pkg::QW + 1);

  logic [63:0]   rem;
  logic [63:0]   dsh;
  logic [CW-1:0] cnt;
  logic          ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= num;
        dsh <= dvs << (tpz_pkg::QW - 1);
        quo <= '0;
        cnt <= CW'(tpz_pkg::QW);
      end else if (cnt != '0) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo  <= {quo[tpz_pkg::QW-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

endmodule

// ===== hw/rtl/tpz_proj.sv =====
// Projection sequencer: one shared multiplier stepped through the torus math.
module tpz_proj #(
  parameter int WIDTH  = tpz_pkg::WIDTH_DEF,
  parameter int HEIGHT = tpz_pkg::HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [9:0]          theta,
  input  logic [9:0]          phi,
  input  logic [9:0]          angle_a,
  input  logic [9:0]          angle_b,
  output logic                done,
  output tpz_pkg::proj_res_t  res
);

  localparam logic [4:0] LAST = 5'd20;

  logic               run;
  logic [4:0]         step;
  logic signed [15:0] st, ct, sp, cp, sa, ca, sb, cb;
  logic signed [16:0] h;
  logic signed [32:0] p1, p2;
  logic signed [31:0] p3, p4, q1, q4;
  logic signed [63:0] mden, mt, q2, q3, q5, u1, v1, u2, v2, l1, dw, dh, u60, v30;
  logic signed [63:0] den, t, inner, u, v, lum;
  logic signed [47:0] ma;
  logic signed [16:0] mb;
  logic signed [64:0] prod;
  logic [9:0]         lsh;
  logic [3:0]         shade;

  assign h     = 17'(cp) + 17'sd32768;
  assign den   = mden + (64'(p3) <<< 14) + (64'sd5 <<< 42);
  assign t     = mt - (64'(p4) <<< 14);
  assign inner = (64'(p4) <<< 14) - q2;
  assign u     = ((u1 <<< 14) - u2) >>> 14;
  assign v     = ((v1 <<< 14) + v2) >>> 14;
  assign lum   = l1 - (q3 <<< 14) - (64'(p3) <<< 28) - (q5 <<< 14);
  assign lsh   = lum[62:53];

  always_comb begin
    if (lum <= 64'sd0) begin
      shade = 4'd0;
    end else if (lsh > 10'd11) begin
      shade = 4'd11;
    end else begin
      shade = lsh[3:0];
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      5'd0:  begin ma = 48'(st);    mb = h;        end
      5'd1:  begin ma = 48'(ct);    mb = h;        end
      5'd2:  begin ma = 48'(p1);    mb = 17'(sa);  end
      5'd3:  begin ma = 48'(p1);    mb = 17'(ca);  end
      5'd4:  begin ma = 48'(sp);    mb = 17'(ca);  end
      5'd5:  begin ma = 48'(sp);    mb = 17'(sa);  end
      5'd6:  begin ma = 48'(st);    mb = 17'(cp);  end
      5'd7:  begin ma = 48'(ct);    mb = 17'(cp);  end
      5'd8:  begin ma = 48'(q1);    mb = 17'(ca);  end
      5'd9:  begin ma = 48'(q1);    mb = 17'(sa);  end
      5'd10: begin ma = 48'(q4);    mb = 17'(sb);  end
      5'd11: begin ma = 48'(p2);    mb = 17'(cb);  end
      5'd12: begin ma = 48'(p2);    mb = 17'(sb);  end
      5'd13: begin ma = 48'(t);     mb = 17'(sb);  end
      5'd14: begin ma = 48'(t);     mb = 17'(cb);  end
      5'd15: begin ma = 48'(inner); mb = 17'(cb);  end
      5'd16: begin ma = 48'(den);   mb = 17'(WIDTH);  end
      5'd17: begin ma = 48'(den);   mb = 17'(HEIGHT); end
      5'd18: begin ma = 48'(u);     mb = 17'sd60;  end
      5'd19: begin ma = 48'(v);     mb = 17'sd30;  end
      default: begin ma = '0;       mb = '0;       end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        st   <= tpz_pkg::sin_code(theta);
        ct   <= tpz_pkg::cos_code(theta);
        sp   <= tpz_pkg::sin_code(phi);
        cp   <= tpz_pkg::cos_code(phi);
        sa   <= tpz_pkg::sin_code(angle_a);
        ca   <= tpz_pkg::cos_code(angle_a);
        sb   <= tpz_pkg::sin_code(angle_b);
        cb   <= tpz_pkg::cos_code(angle_b);
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        case (step)
          5'd0:  p1   <= prod[32:0];
          5'd1:  p2   <= prod[32:0];
          5'd2:  mden <= prod[63:0];
          5'd3:  mt   <= prod[63:0];
          5'd4:  p3   <= prod[31:0];
          5'd5:  p4   <= prod[31:0];
          5'd6:  q1   <= prod[31:0];
          5'd7:  q4   <= prod[31:0];
          5'd8:  q2   <= prod[63:0];
          5'd9:  q3   <= prod[63:0];
          5'd10: q5   <= prod[63:0];
          5'd11: u1   <= prod[63:0];
          5'd12: v1   <= prod[63:0];
          5'd13: u2   <= prod[63:0];
          5'd14: v2   <= prod[63:0];
          5'd15: l1   <= prod[63:0];
          5'd16: dw   <= prod[63:0];
          5'd17: dh   <= prod[63:0];
          5'd18: u60  <= prod[63:0];
          5'd19: v30  <= prod[63:0];
          default: begin
            res.nx    <= dw + u60;
            res.ny    <= dh + v30;
            res.den   <= den[47:0];
            res.shade <= shade;
          end
        endcase
        if (step == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule
